[rtl/qps_pkg.sv]
package qps_pkg;

   // Block configuration
   localparam int NUM_BINS    = 64;
   localparam int GOOD_LEVEL  = 30;
   localparam int COUNT_WIDTH = 16;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 16;
   localparam int LEVEL_W = 8;
   localparam int SCORE_W = 18;

   // Fixed constants of the scoring rule
   localparam int CHAR_OFFSET = 32;
   localparam int PERCENT     = 100;
   localparam int ROUND_HALF  = PERCENT / 2;
   localparam int SCORE_MAX   = (1 << SCORE_W) - 1;

   // Derived widths
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int WALK_W    = $clog2(NUM_BINS + 1);
   localparam int RUN_W     = COUNT_WIDTH + BIN_W;
   localparam int PROD_W    = LEVEL_W + LEN_W;
   localparam int DIV_W     = (COUNT_WIDTH + 1 > PROD_W) ? COUNT_WIDTH + 1 : PROD_W;

   // Reciprocals for exact division of a DIV_W-bit value by a constant:
   // q = (x * ceil(2^sh / d)) >> sh with sh = DIV_W + ceil(log2(d))
   localparam int     RCP_W     = DIV_W + 1;
   localparam int     MUL_W     = DIV_W + RCP_W;
   localparam int     THR_SH    = DIV_W + $clog2(PERCENT);
   localparam int     SCORE_SH  = DIV_W + $clog2(GOOD_LEVEL);
   localparam longint RCP_THR   = ((longint'(1) << THR_SH) + PERCENT - 1) / PERCENT;
   localparam longint RCP_SCORE = ((longint'(1) << SCORE_SH) + GOOD_LEVEL - 1) / GOOD_LEVEL;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_THRESH,
      ST_DIV,
      ST_WALK,
      ST_MUL,
      ST_OUT
   } qps_state_type;

   // Map a raw quality character onto its histogram bin
   function automatic logic [BIN_W-1:0] bin_of(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W:0] ofs;
      ofs = {1'b0, ch} - (CHAR_W + 1)'(CHAR_OFFSET);
      if (ch < CHAR_W'(CHAR_OFFSET)) begin
         return '0;
      end else if (ofs >= (CHAR_W + 1)'(NUM_BINS)) begin
         return BIN_W'(NUM_BINS - 1);
      end else begin
         return ofs[BIN_W-1:0];
      end
   endfunction

endpackage

[rtl/qps_if.sv]
interface qps_req_if;
   import qps_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] quality_char;
   logic              char_valid;
   logic              last;
   logic [LEN_W-1:0]  read_length;

   modport source (output valid, quality_char, char_valid, last, read_length, input ready);
   modport sink   (input valid, quality_char, char_valid, last, read_length, output ready);
endinterface

interface qps_rsp_if;
   import qps_pkg::*;

   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic [LEVEL_W-1:0] percentile_bin;
   logic               used_default;

   modport source (output valid, score, percentile_bin, used_default, input ready);
   modport sink   (input valid, score, percentile_bin, used_default, output ready);
endinterface

[rtl/quality_percentile_score_top.sv]
// Channel   Port     Dir  Beat contents
// -------   ------   ---  ---------------------------------------------------
// request   req_ch   in   quality_char, char_valid, last, read_length
// response  rsp_ch   out  score, percentile_bin, used_default (one per read)
//
// A counted character reads its histogram bin, then writes it back; an
// uncounted non-last beat only passes through idle. The last beat adds the
// end-of-read pass: the threshold division, the bin walk over the single
// histogram read port, the score division, then the response beat. One
// reciprocal multiplier does both divisions.
// Synchronous reset clears the histogram valid bits and the character count
// at once; no clearing pass. req_ch.ready is low while a beat is in work and
// while a response waits; a stalled response holds its payload.
module quality_percentile_score_top (
   input logic         clock,
   input logic         reset,
   qps_req_if.sink     req_ch,
   qps_rsp_if.source   rsp_ch
);
   import qps_pkg::*;

   qps_state_type state_ff, state_in;

   // Histogram storage and its per-entry valid bits
   logic [COUNT_WIDTH-1:0] hist_mem [NUM_BINS];
   logic [NUM_BINS-1:0]    hist_vld_ff, hist_vld_in;
   logic [BIN_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   rd_vld_ff;
   logic [COUNT_WIDTH-1:0] rd_count;
   logic                   mem_we;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   // Per-read context
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic                   last_ff, last_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [COUNT_WIDTH-1:0] cc_ff, cc_in;

   // Bin walk
   logic [COUNT_WIDTH-1:0] thr_ff, thr_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [WALK_W-1:0]      walk_ff, walk_in;
   logic [WALK_W-1:0]      hit_idx;
   logic                   walk_end;

   // Shared divider
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic                 div_score_ff, div_score_in;
   logic [RCP_W-1:0]     recip;
   logic [MUL_W-1:0]     mul_full;
   logic [DIV_W-1:0]     quo_div;

   // Result
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               dflt_ff, dflt_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [PROD_W-1:0]  prod;

   assign rd_count = rd_vld_ff ? rd_data_ff : '0;
   assign hit_idx  = walk_ff - WALK_W'(1);
   assign walk_end = (walk_ff == WALK_W'(NUM_BINS));
   assign prod     = PROD_W'(level_ff) * PROD_W'(len_ff);

   // Divide by the selected constant through its reciprocal
   assign recip    = div_score_ff ? RCP_W'(RCP_SCORE) : RCP_W'(RCP_THR);
   assign mul_full = {{RCP_W{1'b0}}, quo_ff} * {{DIV_W{1'b0}}, recip};
   assign quo_div  = div_score_ff ? DIV_W'(mul_full >> SCORE_SH) : DIV_W'(mul_full >> THR_SH);

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_OUT);
   assign rsp_ch.score         = score_ff;
   assign rsp_ch.percentile_bin = level_ff;
   assign rsp_ch.used_default  = dflt_ff;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hist_vld_ff <= '0;
         cc_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         hist_vld_ff <= hist_vld_in;
         cc_ff       <= cc_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      last_ff      <= last_in;
      len_ff       <= len_in;
      thr_ff       <= thr_in;
      run_ff       <= run_in;
      walk_ff      <= walk_in;
      quo_ff       <= quo_in;
      div_score_ff <= div_score_in;
      level_ff     <= level_in;
      dflt_ff      <= dflt_in;
      score_ff     <= score_in;
   end

   // Histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[bin_ff] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[rd_addr];
      rd_vld_ff  <= hist_vld_ff[rd_addr];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      hist_vld_in  = hist_vld_ff;
      cc_in        = cc_ff;
      bin_in       = bin_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      thr_in       = thr_ff;
      run_in       = run_ff;
      walk_in      = walk_ff;
      quo_in       = quo_ff;
      div_score_in = div_score_ff;
      level_in     = level_ff;
      dflt_in      = dflt_ff;
      score_in     = score_ff;
      mem_we       = 1'b0;
      mem_wdata    = (rd_count == '1) ? rd_count : rd_count + COUNT_WIDTH'(1);
      rd_addr      = bin_of(req_ch.quality_char);

      unique case (state_ff)
         ST_IDLE: begin
            // Capture the beat; its bin is read in the same edge
            if (req_ch.valid) begin
               bin_in  = bin_of(req_ch.quality_char);
               last_in = req_ch.last;
               len_in  = req_ch.read_length;
               if (req_ch.char_valid) begin
                  state_in = ST_UPDATE;
               end else if (req_ch.last) begin
                  state_in = ST_THRESH;
               end
            end
         end

         ST_UPDATE: begin
            // Write back the saturated bin count
            mem_we              = 1'b1;
            hist_vld_in[bin_ff] = 1'b1;
            cc_in               = (cc_ff == '1) ? cc_ff : cc_ff + COUNT_WIDTH'(1);
            state_in            = last_ff ? ST_THRESH : ST_IDLE;
         end

         ST_THRESH: begin
            // Load the divider with the rounded count
            quo_in       = DIV_W'(cc_ff) + DIV_W'(ROUND_HALF);
            div_score_in = 1'b0;
            state_in     = ST_DIV;
         end

         ST_DIV: begin
            if (!div_score_ff) begin
               thr_in   = quo_div[COUNT_WIDTH-1:0];
               run_in   = '0;
               walk_in  = '0;
               state_in = ST_WALK;
            end else begin
               // Saturate, present the result and drop the histogram
               score_in    = (quo_div > DIV_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                          : quo_div[SCORE_W-1:0];
               hist_vld_in = '0;
               cc_in       = '0;
               state_in    = ST_OUT;
            end
         end

         ST_WALK: begin
            // Issue one bin read a cycle; accumulate the bin read last cycle
            rd_addr = walk_end ? '0 : walk_ff[BIN_W-1:0];
            if (!walk_end) begin
               walk_in = walk_ff + WALK_W'(1);
            end
            if (walk_ff != '0) begin
               run_in = run_ff + RUN_W'(rd_count);
               if (run_in > RUN_W'(thr_ff)) begin
                  dflt_in  = (hit_idx == '0);
                  level_in = (hit_idx == '0) ? LEVEL_W'(GOOD_LEVEL)
                                             : LEVEL_W'(hit_idx[BIN_W-1:0]);
                  state_in = ST_MUL;
               end else if (walk_end) begin
                  dflt_in  = 1'b1;
                  level_in = LEVEL_W'(GOOD_LEVEL);
                  state_in = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            // Load the divider with level times length
            quo_in       = DIV_W'(prod);
            div_score_in = 1'b1;
            state_in     = ST_DIV;
         end

         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/qps_checker.sv]
module qps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [qps_pkg::SCORE_W-1:0] rsp_score,
   input logic [qps_pkg::LEVEL_W-1:0] rsp_percentile_bin,
   input logic                        rsp_used_default
);
   import qps_pkg::*;

   // Never take a beat while a response is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // A non-last beat never raises a response on the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last) |=> !rsp_valid)
      else $error("response without a last beat");

   // A response appears only after a last beat's work, so not right after a beat
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (!req_ready && !rsp_valid))
      else $error("last beat finished too early");

   // Default level flag agrees with the reported level
   a_default_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_default ? (rsp_percentile_bin == LEVEL_W'(GOOD_LEVEL))
                                      : (rsp_percentile_bin != '0)))
      else $error("percentile level does not match default flag");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_score)))
      else $error("stalled response changed");

endmodule

bind quality_percentile_score_top qps_checker u_qps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_last           (req_ch.last),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_score          (rsp_ch.score),
   .rsp_percentile_bin (rsp_ch.percentile_bin),
   .rsp_used_default   (rsp_ch.used_default)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import qps_pkg::*;

   // One request beat as the stimulus holds it; hold_back makes the sender
   // wait for all outstanding scores before this beat goes out
   typedef struct {
      logic [CHAR_W-1:0] quality_char;
      logic              char_valid;
      logic              last;
      logic [LEN_W-1:0]  read_length;
      bit                hold_back;
   } qual_beat_type;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic [LEVEL_W-1:0] percentile_bin;
      logic               used_default;
   } read_score_type;

   // Receiver stall modes
   localparam int RX_OPEN   = 0;
   localparam int RX_COIN   = 1;
   localparam int RX_SPARSE = 2;
   localparam int RX_LONG   = 3;

   logic clock;
   logic reset;

   qps_req_if req_ch ();
   qps_rsp_if rsp_ch ();

   quality_percentile_score_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   qual_beat_type  pending_beats[$];
   read_score_type expected_scores[$];

   // Predicted histogram state
   logic [COUNT_WIDTH-1:0] hist_counts[NUM_BINS];
   logic [COUNT_WIDTH-1:0] hist_total;

   int total_beats;
   int accepted_beats;
   int mismatches;

   // Count one accepted beat; on the last beat of a read, score it and clear
   task automatic tally_beat(input qual_beat_type b);
      int unsigned     bin;
      int unsigned     threshold;
      int unsigned     running;
      int unsigned     hit;
      int unsigned     level;
      bit              found;
      longint unsigned prod;
      read_score_type  r;
      if (b.char_valid) begin
         if (int'(b.quality_char) < CHAR_OFFSET) begin
            bin = 0;
         end else if (int'(b.quality_char) - CHAR_OFFSET >= NUM_BINS) begin
            bin = NUM_BINS - 1;
         end else begin
            bin = int'(b.quality_char) - CHAR_OFFSET;
         end
         if (hist_counts[bin] != '1) hist_counts[bin] = hist_counts[bin] + 1'b1;
         if (hist_total != '1) hist_total = hist_total + 1'b1;
      end
      if (b.last) begin
         threshold = (int'(hist_total) + ROUND_HALF) / PERCENT;
         running = 0;
         found = 1'b0;
         hit = 0;
         for (int i = 0; i < NUM_BINS && !found; i++) begin
            running += hist_counts[i];
            if (running > threshold) begin
               found = 1'b1;
               hit = i;
            end
         end
         r.used_default = !found || (hit == 0);
         level = r.used_default ? GOOD_LEVEL : hit;
         prod = (longint'(level) * longint'(b.read_length)) / GOOD_LEVEL;
         if (prod > SCORE_MAX) prod = SCORE_MAX;
         r.score = SCORE_W'(prod);
         r.percentile_bin = LEVEL_W'(level);
         expected_scores.push_back(r);
         foreach (hist_counts[k]) hist_counts[k] = '0;
         hist_total = '0;
      end
   endtask

   task automatic push_beat(input int ch, input bit cv, input bit lst, input int len,
                            input bit hb);
      qual_beat_type b;
      b.quality_char = CHAR_W'(ch);
      b.char_valid = cv;
      b.last = lst;
      b.read_length = LEN_W'(len);
      b.hold_back = hb;
      pending_beats.push_back(b);
   endtask

   // Queue one read of n_chars beats; noisy reads mix in extra uncounted beats
   // and leave some characters uncounted; any read may hold stray characters
   task automatic queue_read(input int n_chars, input bit noisy, input bit hb);
      int base;
      int spread;
      int ch;
      int len;
      bit cv;
      base = $urandom_range(0, NUM_BINS - 1);
      spread = $urandom_range(0, 20);
      for (int i = 0; i < n_chars; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) begin
            push_beat($urandom_range(0, 255), 1'b0, 1'b0, $urandom_range(0, 65535), hb);
            hb = 1'b0;
         end
         if ($urandom_range(0, 99) < 8) ch = $urandom_range(0, 255);
         else ch = CHAR_OFFSET + base + $urandom_range(0, spread);
         cv = 1'b1;
         if (noisy) begin
            if (i == n_chars - 1) cv = ($urandom_range(0, 99) < 85);
            else cv = ($urandom_range(0, 19) != 0);
         end
         len = $urandom_range(0, 65535);
         if (i == n_chars - 1) begin
            case ($urandom_range(0, 7))
               0, 1: len = n_chars;
               2: len = 65535;
               default: ;
            endcase
         end
         push_beat(ch, cv, i == n_chars - 1, len, hb);
         hb = 1'b0;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.quality_char = '0;
      req_ch.char_valid = 1'b0;
      req_ch.last = 1'b0;
      req_ch.read_length = '0;
      rsp_ch.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   // Request driver: bursts of random length with random gaps
   qual_beat_type in_flight;
   int            burst_left;
   int            gap_left;
   bit            present;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.quality_char <= '0;
         req_ch.char_valid <= 1'b0;
         req_ch.last <= 1'b0;
         req_ch.read_length <= '0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tally_beat(in_flight);
            accepted_beats++;
         end
         // hold the beat while it waits for ready
         if (!req_ch.valid || req_ch.ready) begin
            present = 1'b0;
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (pending_beats.size() != 0 &&
                         !(pending_beats[0].hold_back && expected_scores.size() != 0)) begin
               in_flight = pending_beats.pop_front();
               present = 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_ch.valid <= present;
            if (present) begin
               req_ch.quality_char <= in_flight.quality_char;
               req_ch.char_valid <= in_flight.char_valid;
               req_ch.last <= in_flight.last;
               req_ch.read_length <= in_flight.read_length;
            end
         end
      end
   end

   // Response monitor and receiver stall pattern
   logic [15:0] rx_cycle;
   int          rx_mode;

   always @(posedge clock) begin
      read_score_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_cycle <= '0;
         rx_mode <= RX_OPEN;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_scores.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected score beat: score %0d bin %0d default %0b",
                           rsp_ch.score, rsp_ch.percentile_bin, rsp_ch.used_default);
            end else begin
               want = expected_scores.pop_front();
               if (rsp_ch.score !== want.score ||
                   rsp_ch.percentile_bin !== want.percentile_bin ||
                   rsp_ch.used_default !== want.used_default) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("score mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                              want.score, want.percentile_bin, want.used_default,
                              rsp_ch.score, rsp_ch.percentile_bin, rsp_ch.used_default);
               end
            end
         end
         // pick a new random stall mode each time rx_cycle[8:0] returns to zero
         rx_cycle <= rx_cycle + 1'b1;
         if (rx_cycle[8:0] == '0) rx_mode <= $urandom_range(RX_OPEN, RX_LONG);
         case (rx_mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= (rx_cycle[1:0] == 2'd0);
            default:   rsp_ch.ready <= (rx_cycle[5:4] == 2'd0);
         endcase
      end
   end

   // Stimulus and end of run
   initial begin
      int random_beats;
      int sel;
      int n;
      foreach (hist_counts[k]) hist_counts[k] = '0;
      hist_total = '0;
      accepted_beats = 0;
      mismatches = 0;

      // Empty read
      push_beat(0, 1'b0, 1'b1, 0, 1'b0);
      // Lowest character alone lands in bin zero
      push_beat(0, 1'b1, 1'b1, 65535, 1'b0);
      // Characters just below and at the offset share bin zero
      push_beat(31, 1'b1, 1'b0, 0, 1'b0);
      push_beat(32, 1'b1, 1'b0, 65535, 1'b0);
      push_beat(33, 1'b1, 1'b1, 300, 1'b0);
      // High characters clamp to the top bin, with an ignored beat inside
      push_beat(255, 1'b1, 1'b0, 4660, 1'b0);
      push_beat(77, 1'b0, 1'b0, 43981, 1'b0);
      push_beat(CHAR_OFFSET + NUM_BINS, 1'b1, 1'b0, 0, 1'b0);
      push_beat(CHAR_OFFSET + NUM_BINS - 1, 1'b1, 1'b1, 65535, 1'b0);
      // Score truncates to zero
      push_beat(33, 1'b1, 1'b1, GOOD_LEVEL - 1, 1'b0);
      // Only uncounted beats: no bin qualifies
      push_beat(64, 1'b0, 1'b0, 1, 1'b0);
      push_beat(200, 1'b0, 1'b1, 500, 1'b0);
      push_beat(127, 1'b1, 1'b1, 32768, 1'b0);
      // Uncounted last beat closes a counted read
      push_beat(40, 1'b1, 1'b0, 21845, 1'b0);
      push_beat(50, 1'b1, 1'b0, 43690, 1'b0);
      push_beat(170, 1'b0, 1'b1, 12345, 1'b0);

      // Random reads; rounding-edge sizes carry only counted characters
      random_beats = 0;
      while (random_beats < 1750) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            n = $urandom_range(1, 30);
            queue_read(n, 1'b1, random_beats == 0 || $urandom_range(0, 9) == 0);
         end else if (sel < 82) begin
            n = ($urandom_range(0, 1) ? 49 : 149) + $urandom_range(0, 2);
            queue_read(n, 1'b0, $urandom_range(0, 9) == 0);
         end else if (sel < 85) begin
            n = 1;
            push_beat($urandom_range(0, 255), 1'b0, 1'b1, $urandom_range(0, 65535), 1'b0);
         end else begin
            n = $urandom_range(60, 250);
            queue_read(n, 1'b1, $urandom_range(0, 9) == 0);
         end
         random_beats += n;
      end

      total_beats = pending_beats.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Drain: every beat taken, every score back, then a quiet tail
      while (accepted_beats != total_beats) @(posedge clock);
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
